### sv/sorted_counted_multiset_assert.svh
// Assertion macros shared by the sorted counted multiset RTL.
`ifndef SORTED_COUNTED_MULTISET_ASSERT_SVH
`define SORTED_COUNTED_MULTISET_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCM_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("scm assertion failed");

// Next-cycle implication, checked out of reset.
`define SCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("scm assertion failed");

`endif

### sv/scm_pkg.sv
// Types and constants shared by the sorted counted multiset modules.
`timescale 1ns / 1ps
package scm_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int ENTRY_BITS = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_SAT  = 2'd2
  } status_e;

  // What every cell does in the update cycle
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DELETE,
    ACT_INC,
    ACT_DEC
  } act_e;

  typedef struct packed {
    key_t   key;
    count_t cnt;
  } slot_t;

  typedef struct packed {
    act_e act;
    key_t key;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

### sv/scm_cell.sv
// One storage cell of the sorted row: key, count, compare flags and neighbor shift.
`timescale 1ns / 1ps
module scm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scm_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                left_lt_i,
  input  scm_pkg::slot_t      left_i,
  input  scm_pkg::slot_t      right_i,
  output scm_pkg::slot_t      slot_o,
  output scm_pkg::cell_flags_t flags_o
);

  scm_pkg::slot_t       slot_q, slot_d;
  scm_pkg::cell_flags_t flags_q, flags_d;

  // compare against the broadcast key; only occupied cells count
  always_comb begin
    flags_d.lt = valid_i && (slot_q.key < ctrl_i.key);
    flags_d.eq = valid_i && (slot_q.key == ctrl_i.key);
  end

  // update: open a gap, close a gap, or adjust the matching count
  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.act)
      scm_pkg::ACT_INSERT: begin
        if (!flags_q.lt) begin
          if (left_lt_i) begin
            slot_d.key = ctrl_i.key;
            slot_d.cnt = scm_pkg::count_t'(1);
          end else begin
            slot_d = left_i;
          end
        end
      end
      scm_pkg::ACT_DELETE: begin
        if (!flags_q.lt) slot_d = right_i;
      end
      scm_pkg::ACT_INC: begin
        if (flags_q.eq) slot_d.cnt = slot_q.cnt + scm_pkg::count_t'(1);
      end
      scm_pkg::ACT_DEC: begin
        if (flags_q.eq) slot_d.cnt = slot_q.cnt - scm_pkg::count_t'(1);
      end
      default: ;
    endcase
  end

  // payload has no reset; occupancy comes from the fill count
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign slot_o  = slot_q;
  assign flags_o = flags_q;

endmodule

### sv/sorted_counted_multiset.sv
// Top level of the sorted counted multiset: cell row, match reduction and sequencer.
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_stall_o     op_i, key_i
//   out       output     out_valid_o / out_stall_i   found_o, multiplicity_o, entries_o,
//                                                    is_empty_o, status_o
//
// Each item goes through accept, compare in all cells, reduce the match over the
// row, update the row and load the result register; the compare and the match
// reduction across the 64-cell row have own states; no item is taken before the update.
// Reset leaves cell contents as they are; they are meaningful below the fill count.
// The update cycle waits while the result register holds a result not yet taken.
`timescale 1ns / 1ps
`include "sorted_counted_multiset_assert.svh"
module sorted_counted_multiset (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      op_i,
  input  logic [scm_pkg::KEY_BITS-1:0]    key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [scm_pkg::COUNT_BITS-1:0]  multiplicity_o,
  output logic [scm_pkg::ENTRY_BITS-1:0]  entries_o,
  output logic                            is_empty_o,
  output logic [1:0]                      status_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_UPD
  } state_e;

  localparam scm_pkg::count_t CountMax = {scm_pkg::COUNT_BITS{1'b1}};
  localparam scm_pkg::entry_t EntryCap = scm_pkg::entry_t'(scm_pkg::CAPACITY);

  state_e              state_q;
  scm_pkg::op_e        op_q;
  scm_pkg::key_t       key_q;
  scm_pkg::entry_t     used_q, used_d;
  logic                found_q, found_d;
  scm_pkg::count_t     old_cnt_q, old_cnt_d;

  logic                out_valid_q;
  logic                out_found_q;
  scm_pkg::count_t     out_mult_q;
  scm_pkg::entry_t     out_entries_q;
  scm_pkg::status_e    out_status_q;

  scm_pkg::act_e       act_sel;
  scm_pkg::count_t     mult_sel;
  scm_pkg::status_e    status_sel;
  logic                found_sel;
  logic                go;

  scm_pkg::cell_ctrl_t  ctrl;
  scm_pkg::slot_t       slots [scm_pkg::CAPACITY];
  scm_pkg::cell_flags_t flags [scm_pkg::CAPACITY];
  logic [scm_pkg::CAPACITY-1:0] occ;

  // cell row
  for (genvar i = 0; i < scm_pkg::CAPACITY; i++) begin : g_cell
    logic           left_lt;
    scm_pkg::slot_t left_slot, right_slot;

    assign occ[i] = used_q > scm_pkg::entry_t'(i);

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_slot = slots[i];
    end else begin : g_mid
      assign left_lt   = flags[i-1].lt;
      assign left_slot = slots[i-1];
    end

    if (i == scm_pkg::CAPACITY - 1) begin : g_last
      assign right_slot = slots[i];
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    scm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .valid_i   (occ[i]),
      .left_lt_i (left_lt),
      .left_i    (left_slot),
      .right_i   (right_slot),
      .slot_o    (slots[i]),
      .flags_o   (flags[i])
    );
  end

  // match reduction: at most one cell matches
  always_comb begin
    found_d   = 1'b0;
    old_cnt_d = '0;
    for (int i = 0; i < scm_pkg::CAPACITY; i++) begin
      found_d   = found_d | flags[i].eq;
      old_cnt_d = old_cnt_d | (flags[i].eq ? slots[i].cnt : '0);
    end
  end

  // operation decode for the update cycle
  always_comb begin
    act_sel    = scm_pkg::ACT_HOLD;
    used_d     = used_q;
    mult_sel   = '0;
    status_sel = scm_pkg::STS_OK;
    found_sel  = found_q;
    case (op_q)
      scm_pkg::OP_INSERT: begin
        if (found_q) begin
          if (old_cnt_q == CountMax) begin
            status_sel = scm_pkg::STS_SAT;
            mult_sel   = old_cnt_q;
          end else begin
            act_sel  = scm_pkg::ACT_INC;
            mult_sel = old_cnt_q + scm_pkg::count_t'(1);
          end
        end else if (used_q == EntryCap) begin
          status_sel = scm_pkg::STS_FULL;
        end else begin
          act_sel  = scm_pkg::ACT_INSERT;
          used_d   = used_q + scm_pkg::entry_t'(1);
          mult_sel = scm_pkg::count_t'(1);
        end
      end
      scm_pkg::OP_REMOVE: begin
        if (found_q) begin
          if (old_cnt_q > scm_pkg::count_t'(1)) begin
            act_sel  = scm_pkg::ACT_DEC;
            mult_sel = old_cnt_q - scm_pkg::count_t'(1);
          end else begin
            act_sel = scm_pkg::ACT_DELETE;
            used_d  = used_q - scm_pkg::entry_t'(1);
          end
        end
      end
      scm_pkg::OP_QUERY: begin
        if (found_q) mult_sel = old_cnt_q;
      end
      scm_pkg::OP_CLEAR: begin
        used_d    = '0;
        found_sel = 1'b0;
      end
      default: ;
    endcase
  end

  assign go       = (state_q == ST_UPD) && !(out_valid_q && out_stall_i);
  assign ctrl.act = go ? act_sel : scm_pkg::ACT_HOLD;
  assign ctrl.key = key_q;

  // sequencer, fill count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= scm_pkg::OP_QUERY;
      key_q         <= '0;
      used_q        <= '0;
      found_q       <= 1'b0;
      old_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_mult_q    <= '0;
      out_entries_q <= '0;
      out_status_q  <= scm_pkg::STS_OK;
    end else begin
      // result taken with nothing new to load
      if (out_valid_q && !out_stall_i && !go) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= scm_pkg::op_e'(op_i);
            key_q   <= key_i;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: state_q <= ST_RED;
        ST_RED: begin
          found_q   <= found_d;
          old_cnt_q <= old_cnt_d;
          state_q   <= ST_UPD;
        end
        ST_UPD: begin
          if (go) begin
            used_q        <= used_d;
            out_valid_q   <= 1'b1;
            out_found_q   <= found_sel;
            out_mult_q    <= mult_sel;
            out_entries_q <= used_d;
            out_status_q  <= status_sel;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign multiplicity_o = out_mult_q;
  assign entries_o      = out_entries_q;
  assign is_empty_o     = out_entries_q == '0;
  assign status_o       = out_status_q;

  // checks
  `SCM_ASSERT_IMP(a_used_in_range, clk_i, rst_ni, 1'b1, used_q <= EntryCap)
  `SCM_ASSERT_IMP(a_full_means_cap, clk_i, rst_ni, out_valid_q && out_status_q == scm_pkg::STS_FULL, out_entries_q == EntryCap && !out_found_q)
  `SCM_ASSERT_IMP(a_sat_means_max, clk_i, rst_ni, out_valid_q && out_status_q == scm_pkg::STS_SAT, out_found_q && out_mult_q == CountMax)
  `SCM_ASSERT_NEXT(a_update_loads_result, clk_i, rst_ni, go, out_valid_q && state_q == ST_IDLE)

  for (genvar i = 0; i < scm_pkg::CAPACITY - 1; i++) begin : g_order_chk
    `SCM_ASSERT_IMP(a_row_sorted, clk_i, rst_ni, occ[i+1], slots[i].key < slots[i+1].key)
  end

endmodule
